>>> hdl/bmmb_pkg.sv
// Package: shared types, codes and address map for the banked memory bus.
`default_nettype none
package bmmb_pkg;

  localparam int unsigned AddrW = 16;
  localparam int unsigned DataW = 16;
  localparam int unsigned LenW = 9;
  localparam int unsigned MaxCopyLen = 256;
  localparam int unsigned MemDepth = 65536;

  typedef enum logic [2:0] {
    ACT_RD8  = 3'd0,
    ACT_RD16 = 3'd1,
    ACT_WR8  = 3'd2,
    ACT_WR16 = 3'd3,
    ACT_COPY = 3'd4
  } action_t;

  // classified command passed from front to back
  typedef struct packed {
    action_t            act;
    logic [AddrW-1:0]   addr;
    logic [DataW-1:0]   wdata;
    logic [AddrW-1:0]   src;
    logic [LenW-1:0]    len;
  } cmd_t;

  // map a bus address to physical storage index; echo folded, holes flagged
  function automatic logic [AddrW:0] map_addr(input logic [AddrW-1:0] a);
    logic [AddrW-1:0] p;
    logic             hole;
    p = a;
    if (a >= 16'hE000 && a < 16'hFE00) p = a - 16'h2000;
    hole = (p >= 16'hFEA0 && p < 16'hFF00) || (p == 16'hFFFF);
    return {hole, p};
  endfunction

endpackage
`default_nettype wire

>>> hdl/bmmb_front.sv
// Front end: accept words, validate action, clamp copy length, push to queue.
`default_nettype none
module bmmb_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [2:0]                    in_action,
  input  wire logic [bmmb_pkg::AddrW-1:0]    in_address,
  input  wire logic [bmmb_pkg::DataW-1:0]    in_write_value,
  input  wire logic [bmmb_pkg::AddrW-1:0]    in_source_address,
  input  wire logic [bmmb_pkg::LenW-1:0]     in_copy_length,
  output logic                               q_valid,
  output bmmb_pkg::cmd_t                     q_cmd,
  input  wire logic                          q_pop
);
  // two-entry queue
  bmmb_pkg::cmd_t   mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             push, legal;
  bmmb_pkg::cmd_t   c;

  assign in_stall = (cnt_r == 2'd2);
  assign legal = (in_action <= 3'd4);
  assign push = in_valid && !in_stall && legal;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = mem_r[rp_r];

  always_comb begin
    c.act   = bmmb_pkg::action_t'(in_action);
    c.addr  = in_address;
    c.wdata = in_write_value;
    c.src   = in_source_address;
    c.len   = (in_copy_length > bmmb_pkg::LenW'(bmmb_pkg::MaxCopyLen)) ?
              bmmb_pkg::LenW'(bmmb_pkg::MaxCopyLen) : in_copy_length;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

>>> hdl/bmmb_back.sv
// Back end: byte memory with clear sweep, executes reads, writes and copies.
`default_nettype none
module bmmb_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  bmmb_pkg::cmd_t                     q_cmd,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bmmb_pkg::DataW-1:0]         out_read_data,
  output logic                               clearing
);
  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_RD0  = 6'b000100,
    S_RD1  = 6'b001000,
    S_CPR  = 6'b010000,
    S_CPW  = 6'b100000
  } state_t;

  logic [7:0]   mem [bmmb_pkg::MemDepth];
  state_t       st_r, st_nxt;
  logic [15:0]  clr_r, clr_nxt;
  bmmb_pkg::cmd_t cmd_r, cmd_nxt;
  logic [8:0]   idx_r, idx_nxt;
  logic [7:0]   rd_r;
  logic [7:0]   lo_r, lo_nxt;
  logic         holeq_r;
  logic         ov_r, ov_nxt;
  logic [15:0]  od_r, od_nxt;
  logic         we;
  logic [15:0]  wa, ra;
  logic [7:0]   wd;
  logic [16:0]  rm, wm;
  logic         re;
  logic [7:0]   rdv;

  assign clearing = (st_r == S_CLR);
  assign out_valid = ov_r;
  assign out_read_data = od_r;

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; cmd_nxt = cmd_r; idx_nxt = idx_r;
    lo_nxt = lo_r; ov_nxt = ov_r; od_nxt = od_r;
    q_pop = 1'b0; we = 1'b0; wa = '0; wd = '0; ra = '0; re = 1'b0;
    wm = '0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (st_r)
      S_CLR: begin
        we = 1'b1; wa = clr_r; wd = 8'h00;
        clr_nxt = clr_r + 16'd1;
        if (clr_r == 16'hFFFF) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid && !ov_nxt) begin
          q_pop = 1'b1; cmd_nxt = q_cmd; idx_nxt = '0;
          unique case (q_cmd.act)
            bmmb_pkg::ACT_RD8, bmmb_pkg::ACT_RD16: begin
              ra = q_cmd.addr; re = 1'b1; st_nxt = S_RD0;
            end
            bmmb_pkg::ACT_WR8: begin
              wm = bmmb_pkg::map_addr(q_cmd.addr);
              we = !wm[16]; wa = wm[15:0]; wd = q_cmd.wdata[7:0];
            end
            bmmb_pkg::ACT_WR16: begin
              wm = bmmb_pkg::map_addr(q_cmd.addr);
              we = !wm[16]; wa = wm[15:0]; wd = q_cmd.wdata[7:0];
              cmd_nxt.addr = q_cmd.addr + 16'd1;
              cmd_nxt.wdata = {8'h00, q_cmd.wdata[15:8]};
              cmd_nxt.act = bmmb_pkg::ACT_WR8;
              cmd_nxt.len = 9'd1;
              st_nxt = S_CPW;
            end
            bmmb_pkg::ACT_COPY: begin
              if (q_cmd.len != 9'd0) begin
                ra = q_cmd.src; re = 1'b1; st_nxt = S_CPR;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD0: begin
        if (cmd_r.act == bmmb_pkg::ACT_RD8) begin
          ov_nxt = 1'b1; od_nxt = {8'h00, rdv}; st_nxt = S_IDLE;
        end else begin
          lo_nxt = rdv; ra = cmd_r.addr + 16'd1; re = 1'b1; st_nxt = S_RD1;
        end
      end
      S_RD1: begin
        ov_nxt = 1'b1; od_nxt = {rdv, lo_r}; st_nxt = S_IDLE;
      end
      S_CPR: begin
        // read data now valid: write destination byte
        wm = bmmb_pkg::map_addr(cmd_r.addr + 16'(idx_r));
        we = !wm[16]; wa = wm[15:0]; wd = rdv;
        idx_nxt = idx_r + 9'd1;
        if (idx_nxt == cmd_r.len) st_nxt = S_IDLE;
        else begin
          ra = cmd_r.src + 16'(idx_nxt); re = 1'b1;
        end
      end
      S_CPW: begin
        // second byte of a 16-bit write
        wm = bmmb_pkg::map_addr(cmd_r.addr);
        we = !wm[16]; wa = wm[15:0]; wd = cmd_r.wdata[7:0];
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // copy reads the next source byte while writing the current one; forward
  // a same-cycle write to the read port so an overlapping copy sees it
  always_comb rm = bmmb_pkg::map_addr(ra);

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) begin
      if (we && (wa == rm[15:0])) rd_r <= wd;
      else rd_r <= mem[rm[15:0]];
      holeq_r <= rm[16];
    end
  end

  always_comb rdv = holeq_r ? 8'h00 : rd_r;

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; idx_r <= idx_nxt; lo_r <= lo_nxt; od_r <= od_nxt;
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; ov_r <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

>>> hdl/banked_memory_map_bus.sv
// Top level: banked 16-bit memory map bus with echo region and block copy.
// A word is registered in the queue before it is popped; a byte read passes
// state RD0, a 16-bit read RD0 and RD1. Throughput: a word is popped only when
// the back end is idle and holds no result; a copy moves one byte per cycle,
// the next source read overlapping the current write on the store's separate
// read and write ports. Reset: synchronous active-low; afterward a clearing
// pass zeroes all 65536 bytes of the store, during which input words stall.
`default_nettype none
module banked_memory_map_bus (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_action,
  input  wire logic [15:0] in_address,
  input  wire logic [15:0] in_write_value,
  input  wire logic [15:0] in_source_address,
  input  wire logic [8:0]  in_copy_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_read_data
);
  logic           q_valid, q_pop, clearing, f_stall;
  bmmb_pkg::cmd_t q_cmd;

  // hold input off while the store is being cleared
  assign in_stall = f_stall || clearing;

  bmmb_front u_front (
    .clk, .rst_n,
    .in_valid(in_valid && !clearing), .in_stall(f_stall),
    .in_action, .in_address, .in_write_value, .in_source_address,
    .in_copy_length, .q_valid, .q_cmd, .q_pop
  );

  bmmb_back u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop,
    .out_valid, .out_stall, .out_read_data, .clearing
  );

  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid) else $error("result during clear");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data))
    else $error("result dropped");
  a_pop_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop of empty queue");
endmodule
`default_nettype wire
